### design/cnbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cnbs_pkg;

  // Port and field widths.
  localparam int COLOR_W    = 2;
  localparam int FRAMES_W   = 17;
  localparam int NOISE_W    = 16;
  localparam int SAMPLE_W   = 24;
  localparam int PEAK_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Burst length limit and the width used to compare against it.
  localparam int MAX_FRAMES_DEF = 65536;
  localparam int MAXF_W         = 21;

  // Shared multiplier: signed A by signed B, product rounded by 2^-16.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int RND_W   = MUL_P_W - 16;

  // Internal datapath widths.
  localparam int VIN_W   = NOISE_W + 1;
  localparam int POLE_W  = 32;
  localparam int SUM_W   = 34;
  localparam int BROWN_W = 18;
  localparam int VAL_W   = 32;
  localparam int SQ_W    = 2 * FRAMES_W;
  localparam int ENV_W   = 17;
  localparam int CNT_W   = 4;

  localparam logic [ENV_W-1:0]    ENV_ONE       = 17'd65536;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET  = 17'd4800;
  localparam logic [CNT_W-1:0]    DIV_LAST_STEP = 4'd15;

  // Color codes.
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_PINK  = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_BROWN = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_COLOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_FRAMES = 2'd1;

  // Signed Q2.16 coefficients.
  localparam logic signed [MUL_B_W-1:0] C_P0_A    = 18'sd65382;
  localparam logic signed [MUL_B_W-1:0] C_P0_B    = 18'sd6491;
  localparam logic signed [MUL_B_W-1:0] C_P1_A    = 18'sd63111;
  localparam logic signed [MUL_B_W-1:0] C_P1_B    = 18'sd19432;
  localparam logic signed [MUL_B_W-1:0] C_P2_A    = 18'sd37356;
  localparam logic signed [MUL_B_W-1:0] C_P2_B    = 18'sd68989;
  localparam logic signed [MUL_B_W-1:0] C_DIRECT  = 18'sd12111;
  localparam logic signed [MUL_B_W-1:0] C_BROWN   = 18'sd1311;
  localparam logic signed [MUL_B_W-1:0] C_GAIN    = 18'sd39322;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQ_D,
    ST_SQ_N,
    ST_SEL,
    ST_P0A,
    ST_P0B,
    ST_P1A,
    ST_P1B,
    ST_P2A,
    ST_P2B,
    ST_PDIR,
    ST_PSUM,
    ST_PQUART,
    ST_BRN,
    ST_BRN_WB,
    ST_DIV_INIT,
    ST_DIV,
    ST_ENV,
    ST_ENV_WB,
    ST_GAIN,
    ST_GAIN_WB,
    ST_FIN
  } cnbs_state_t;

  // Destination of the product that sits in the multiplier register.
  typedef enum logic [3:0] {
    TG_NONE,
    TG_DSQ,
    TG_NSQ,
    TG_FB,
    TG_SLOW,
    TG_MID,
    TG_FAST,
    TG_DIRECT,
    TG_BROWN,
    TG_ENV,
    TG_GAIN
  } cnbs_tag_t;

endpackage

`default_nettype wire

### design/colored_noise_burst_shaper_unit.sv
// Colored noise burst shaper.
// Input channel: one white-noise beat per frame (in_valid, in_stall,
// in_noise_value in Q1.15). Result channel: one beat per input beat
// (out_valid, out_stall, out_shaped_sample in Q8.16, out_last_frame,
// out_peak_magnitude). Configuration: cfg_we writes cfg_data into register
// cfg_index (0 noise color, 1 burst length); write only while idle.
// One item occupies the block from acceptance until its result is loaded:
// a single registered 32x18 multiplier is stepped through the squares, filter,
// envelope and gain products, and the envelope division is a 17-step
// restoring divider. Pink items take the most steps, then brown, then white;
// the next beat is accepted only after the result has been loaded.
// in_stall is high whenever an item is in progress.
// A finished result waits in the output register while the receiver stalls;
// the block can accept and work on the next item meanwhile, and holds it at
// its last step until the output register is free.
// Reset (rst_n low, synchronous) restores color white, burst length 4800,
// and clears the filter states, frame counter, peak and output valid.
`timescale 1ns / 1ps
`default_nettype none

module colored_noise_burst_shaper_unit #(
  parameter int MAX_FRAMES = cnbs_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [cnbs_pkg::NOISE_W-1:0]   in_noise_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [cnbs_pkg::SAMPLE_W-1:0]       out_shaped_sample,
  output logic                                       out_last_frame,
  output logic        [cnbs_pkg::PEAK_W-1:0]         out_peak_magnitude,
  input  wire logic                                  cfg_we,
  input  wire logic   [cnbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic   [cnbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import cnbs_pkg::*;

  localparam logic [MAXF_W-1:0] MAX_F = MAXF_W'(MAX_FRAMES);

  localparam logic signed [POLE_W+2:0]  S32_MAX = 35'sd2147483647;
  localparam logic signed [POLE_W+2:0]  S32_MIN = -35'sd2147483648;
  localparam logic signed [19:0]        BRN_HI  = 20'sd65536;
  localparam logic signed [19:0]        BRN_LO  = -20'sd65536;
  localparam logic signed [RND_W-1:0]   Y_MAX   = 34'sd8388607;
  localparam logic signed [RND_W-1:0]   Y_MIN   = -34'sd8388608;
  localparam logic [PEAK_W-1:0]         MAG_MAX = 23'd8388607;

  function automatic logic signed [POLE_W-1:0] sat32(input logic signed [POLE_W+2:0] x);
    logic signed [POLE_W-1:0] r;
    if (x > S32_MAX) begin
      r = S32_MAX[POLE_W-1:0];
    end else if (x < S32_MIN) begin
      r = S32_MIN[POLE_W-1:0];
    end else begin
      r = x[POLE_W-1:0];
    end
    return r;
  endfunction

  cnbs_state_t state_r, state_nxt;
  cnbs_tag_t   tag_r, tag_nxt;

  logic [COLOR_W-1:0]  color_r, color_nxt, item_color_r, item_color_nxt;
  logic [FRAMES_W-1:0] burst_r, burst_nxt;
  logic [FRAMES_W-1:0] frame_r, frame_nxt;
  logic [FRAMES_W-1:0] n_r, n_nxt, d_r, d_nxt;
  logic                last_r, last_nxt;
  logic [PEAK_W-1:0]   peak_r, peak_nxt;

  logic signed [VIN_W-1:0]   v_r, v_nxt;
  logic signed [POLE_W-1:0]  slow_r, slow_nxt, mid_r, mid_nxt, fast_r, fast_nxt;
  logic signed [RND_W-1:0]   acc_r, acc_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic signed [BROWN_W-1:0] brown_r, brown_nxt;
  logic signed [VAL_W-1:0]   value_r, value_nxt, t_r, t_nxt;
  logic signed [SAMPLE_W-1:0] y_r, y_nxt;

  logic [SQ_W-1:0]   dsq_r, dsq_nxt, nsq_r, nsq_nxt, rem_r, rem_nxt;
  logic [ENV_W-1:0]  q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [PEAK_W-1:0]          out_peak_r, out_peak_nxt;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic signed [RND_W-1:0]   mul_rnd;

  logic                in_acc;
  logic                can_load;
  logic                load_out;
  logic [FRAMES_W-1:0] n_c;
  logic [MAXF_W-1:0]   burst_ext;
  logic signed [POLE_W+2:0] pole_new;
  logic signed [19:0]  brown_sum;
  logic [SQ_W:0]       rem_sh;
  logic                div_ge;
  logic [PEAK_W-1:0]   mag;

  cnbs_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (mul_prod),
    .rnd    (mul_rnd)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign load_out  = (state_r == ST_FIN) && can_load;

  assign out_valid          = out_valid_r;
  assign out_shaped_sample  = out_sample_r;
  assign out_last_frame     = out_last_r;
  assign out_peak_magnitude = out_peak_r;

  // Effective burst length: zero counts as one, long bursts are capped.
  assign burst_ext = {{(MAXF_W-FRAMES_W){1'b0}}, burst_r};
  always_comb begin
    if (burst_r == '0) begin
      n_c = FRAMES_W'(1);
    end else if (burst_ext > MAX_F) begin
      n_c = MAX_F[FRAMES_W-1:0];
    end else begin
      n_c = burst_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_acc) state_nxt = ST_SQ_D;
      ST_SQ_D:     state_nxt = ST_SQ_N;
      ST_SQ_N:     state_nxt = ST_SEL;
      ST_SEL: begin
        if (item_color_r == COLOR_PINK) begin
          state_nxt = ST_P0A;
        end else if (item_color_r == COLOR_BROWN) begin
          state_nxt = ST_BRN;
        end else begin
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_P0A:      state_nxt = ST_P0B;
      ST_P0B:      state_nxt = ST_P1A;
      ST_P1A:      state_nxt = ST_P1B;
      ST_P1B:      state_nxt = ST_P2A;
      ST_P2A:      state_nxt = ST_P2B;
      ST_P2B:      state_nxt = ST_PDIR;
      ST_PDIR:     state_nxt = ST_PSUM;
      ST_PSUM:     state_nxt = ST_PQUART;
      ST_PQUART:   state_nxt = ST_DIV_INIT;
      ST_BRN:      state_nxt = ST_BRN_WB;
      ST_BRN_WB:   state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV:      if (cnt_r == DIV_LAST_STEP) state_nxt = ST_ENV;
      ST_ENV:      state_nxt = ST_ENV_WB;
      ST_ENV_WB:   state_nxt = ST_GAIN;
      ST_GAIN:     state_nxt = ST_GAIN_WB;
      ST_GAIN_WB:  state_nxt = ST_FIN;
      ST_FIN:      if (can_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Multiplier issue: operands and where the product goes next cycle.
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    tag_nxt = TG_NONE;
    case (state_r)
      ST_SQ_D: begin
        op_a    = {{(MUL_A_W-FRAMES_W){1'b0}}, d_r};
        op_b    = {{(MUL_B_W-FRAMES_W){1'b0}}, d_r};
        tag_nxt = TG_DSQ;
      end
      ST_SQ_N: begin
        op_a    = {{(MUL_A_W-FRAMES_W){1'b0}}, n_r};
        op_b    = {{(MUL_B_W-FRAMES_W){1'b0}}, n_r};
        tag_nxt = TG_NSQ;
      end
      ST_P0A: begin
        op_a    = slow_r;
        op_b    = C_P0_A;
        tag_nxt = TG_FB;
      end
      ST_P0B: begin
        op_a    = {{(MUL_A_W-VIN_W){v_r[VIN_W-1]}}, v_r};
        op_b    = C_P0_B;
        tag_nxt = TG_SLOW;
      end
      ST_P1A: begin
        op_a    = mid_r;
        op_b    = C_P1_A;
        tag_nxt = TG_FB;
      end
      ST_P1B: begin
        op_a    = {{(MUL_A_W-VIN_W){v_r[VIN_W-1]}}, v_r};
        op_b    = C_P1_B;
        tag_nxt = TG_MID;
      end
      ST_P2A: begin
        op_a    = fast_r;
        op_b    = C_P2_A;
        tag_nxt = TG_FB;
      end
      ST_P2B: begin
        op_a    = {{(MUL_A_W-VIN_W){v_r[VIN_W-1]}}, v_r};
        op_b    = C_P2_B;
        tag_nxt = TG_FAST;
      end
      ST_PDIR: begin
        op_a    = {{(MUL_A_W-VIN_W){v_r[VIN_W-1]}}, v_r};
        op_b    = C_DIRECT;
        tag_nxt = TG_DIRECT;
      end
      ST_BRN: begin
        op_a    = {{(MUL_A_W-VIN_W){v_r[VIN_W-1]}}, v_r};
        op_b    = C_BROWN;
        tag_nxt = TG_BROWN;
      end
      ST_ENV: begin
        op_a    = value_r;
        op_b    = {{(MUL_B_W-ENV_W){1'b0}}, q_r};
        tag_nxt = TG_ENV;
      end
      ST_GAIN: begin
        op_a    = t_r;
        op_b    = C_GAIN;
        tag_nxt = TG_GAIN;
      end
      default: begin
        tag_nxt = TG_NONE;
      end
    endcase
  end

  assign pole_new  = {{3{acc_r[RND_W-1]}}, acc_r[POLE_W-1:0]} + {mul_rnd[RND_W-1], mul_rnd};
  assign brown_sum = {{2{brown_r[BROWN_W-1]}}, brown_r} + mul_rnd[19:0];
  assign rem_sh    = {rem_r, 1'b0};
  assign div_ge    = (rem_sh >= {1'b0, nsq_r});

  always_comb begin
    if (y_r[SAMPLE_W-1]) begin
      if (y_r == Y_MIN[SAMPLE_W-1:0]) begin
        mag = MAG_MAX;
      end else begin
        mag = PEAK_W'(-y_r);
      end
    end else begin
      mag = y_r[PEAK_W-1:0];
    end
  end

  // Datapath next values.
  always_comb begin
    color_nxt      = color_r;
    burst_nxt      = burst_r;
    item_color_nxt = item_color_r;
    frame_nxt      = frame_r;
    n_nxt          = n_r;
    d_nxt          = d_r;
    last_nxt       = last_r;
    peak_nxt       = peak_r;
    v_nxt          = v_r;
    slow_nxt       = slow_r;
    mid_nxt        = mid_r;
    fast_nxt       = fast_r;
    acc_nxt        = acc_r;
    sum_nxt        = sum_r;
    brown_nxt      = brown_r;
    value_nxt      = value_r;
    t_nxt          = t_r;
    y_nxt          = y_r;
    dsq_nxt        = dsq_r;
    nsq_nxt        = nsq_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    out_last_nxt   = out_last_r;
    out_peak_nxt   = out_peak_r;

    if (cfg_we) begin
      if (cfg_index == REG_NOISE_COLOR) begin
        color_nxt = cfg_data[COLOR_W-1:0];
      end else if (cfg_index == REG_BURST_FRAMES) begin
        burst_nxt = cfg_data[FRAMES_W-1:0];
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          v_nxt          = {in_noise_value, 1'b0};
          item_color_nxt = color_r;
          n_nxt          = n_c;
          d_nxt          = (frame_r < n_c) ? FRAMES_W'(n_c - frame_r) : '0;
          last_nxt       = ({1'b0, frame_r} + (FRAMES_W+1)'(1)) >= {1'b0, n_c};
        end
      end
      ST_SEL: begin
        value_nxt = {{(VAL_W-VIN_W){v_r[VIN_W-1]}}, v_r};
      end
      ST_PQUART: begin
        // Scaling by 1/4 with round half up is (sum + 2) >> 2.
        value_nxt = VAL_W'((sum_r + SUM_W'(2)) >>> 2);
      end
      ST_DIV_INIT: begin
        // The envelope ratio is at most one, so the integer bit needs no shift.
        if (dsq_r >= nsq_r) begin
          rem_nxt = dsq_r - nsq_r;
          q_nxt   = ENV_W'(1);
        end else begin
          rem_nxt = dsq_r;
          q_nxt   = '0;
        end
        cnt_nxt = '0;
      end
      ST_DIV: begin
        rem_nxt = div_ge ? SQ_W'(rem_sh - {1'b0, nsq_r}) : rem_sh[SQ_W-1:0];
        q_nxt   = {q_r[ENV_W-2:0], div_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_FIN: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = y_r;
          out_last_nxt   = last_r;
          out_peak_nxt   = (mag > peak_r) ? mag : peak_r;
          if (last_r) begin
            slow_nxt  = '0;
            mid_nxt   = '0;
            fast_nxt  = '0;
            brown_nxt = '0;
            frame_nxt = '0;
            peak_nxt  = '0;
          end else begin
            frame_nxt = frame_r + FRAMES_W'(1);
            peak_nxt  = (mag > peak_r) ? mag : peak_r;
          end
        end
      end
      default: begin
      end
    endcase

    case (tag_r)
      TG_DSQ:    dsq_nxt = mul_prod[SQ_W-1:0];
      TG_NSQ:    nsq_nxt = mul_prod[SQ_W-1:0];
      TG_FB:     acc_nxt = mul_rnd;
      TG_SLOW: begin
        slow_nxt = sat32(pole_new);
        sum_nxt  = SUM_W'(sat32(pole_new));
      end
      TG_MID: begin
        mid_nxt = sat32(pole_new);
        sum_nxt = sum_r + SUM_W'(sat32(pole_new));
      end
      TG_FAST: begin
        fast_nxt = sat32(pole_new);
        sum_nxt  = sum_r + SUM_W'(sat32(pole_new));
      end
      TG_DIRECT: sum_nxt = sum_r + mul_rnd;
      TG_BROWN: begin
        if (brown_sum > BRN_HI) begin
          brown_nxt = BRN_HI[BROWN_W-1:0];
        end else if (brown_sum < BRN_LO) begin
          brown_nxt = BRN_LO[BROWN_W-1:0];
        end else begin
          brown_nxt = brown_sum[BROWN_W-1:0];
        end
        value_nxt = VAL_W'(brown_nxt);
      end
      TG_ENV:    t_nxt = mul_rnd[VAL_W-1:0];
      TG_GAIN: begin
        if (mul_rnd > Y_MAX) begin
          y_nxt = Y_MAX[SAMPLE_W-1:0];
        end else if (mul_rnd < Y_MIN) begin
          y_nxt = Y_MIN[SAMPLE_W-1:0];
        end else begin
          y_nxt = mul_rnd[SAMPLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Control and burst state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tag_r       <= TG_NONE;
      color_r     <= COLOR_WHITE;
      burst_r     <= FRAMES_RESET;
      frame_r     <= '0;
      peak_r      <= '0;
      slow_r      <= '0;
      mid_r       <= '0;
      fast_r      <= '0;
      brown_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag_r       <= tag_nxt;
      color_r     <= color_nxt;
      burst_r     <= burst_nxt;
      frame_r     <= frame_nxt;
      peak_r      <= peak_nxt;
      slow_r      <= slow_nxt;
      mid_r       <= mid_nxt;
      fast_r      <= fast_nxt;
      brown_r     <= brown_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    item_color_r <= item_color_nxt;
    n_r          <= n_nxt;
    d_r          <= d_nxt;
    last_r       <= last_nxt;
    v_r          <= v_nxt;
    acc_r        <= acc_nxt;
    sum_r        <= sum_nxt;
    value_r      <= value_nxt;
    t_r          <= t_nxt;
    y_r          <= y_nxt;
    dsq_r        <= dsq_nxt;
    nsq_r        <= nsq_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
    out_peak_r   <= out_peak_nxt;
  end

`ifndef ASSERT_OFF
  a_brown_range: assert property (@(posedge clk) disable iff (!rst_n)
    (brown_r >= $signed(BRN_LO[BROWN_W-1:0])) && (brown_r <= $signed(BRN_HI[BROWN_W-1:0])))
    else $error("brown level left its clamp range");

  a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ENV) |-> (q_r <= ENV_ONE))
    else $error("envelope quotient above one");

  a_burst_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && last_r) |=> (frame_r == '0) && (peak_r == '0) && (slow_r == '0))
    else $error("burst state not cleared after last frame");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && out_stall) |=> (state_r == ST_FIN))
    else $error("result overwrote a stalled output beat");
`endif

endmodule

`default_nettype wire

### design/cnbs_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module cnbs_mul #(
  parameter int A_W = cnbs_pkg::MUL_A_W,
  parameter int B_W = cnbs_pkg::MUL_B_W
) (
  input  wire logic                       clk,
  input  wire logic signed [A_W-1:0]      op_a,
  input  wire logic signed [B_W-1:0]      op_b,
  output logic signed [A_W+B_W-1:0]       prod_r,
  output logic signed [A_W+B_W-17:0]      rnd
);

  localparam int P_W = A_W + B_W;

  logic signed [P_W-1:0] prod_nxt;
  logic signed [P_W-1:0] rsum;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Round to nearest with ties upward, then drop the 16 fraction bits.
  assign rsum = prod_r + $signed({{(P_W-16){1'b0}}, 16'h8000});
  assign rnd  = rsum[P_W-1:16];

endmodule

`default_nettype wire

### verif/tb_colored_noise_burst_shaper_unit.sv
`timescale 1ns / 1ps

module tb_colored_noise_burst_shaper_unit;
  import cnbs_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int FRAME_CAP     = 65536;

  localparam logic [FRAMES_W-1:0]  RESET_FRAMES = 17'd4800;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B  = 2'd3;
  localparam logic [COLOR_W-1:0]   COLOR_SPARE  = 2'd3;

  // Q2.16 coefficients of the filters, the brown step, the quarter and the gain.
  localparam longint K_SLOW_FB  = 65382;
  localparam longint K_SLOW_IN  = 6491;
  localparam longint K_MID_FB   = 63111;
  localparam longint K_MID_IN   = 19432;
  localparam longint K_FAST_FB  = 37356;
  localparam longint K_FAST_IN  = 68989;
  localparam longint K_DIRECT   = 12111;
  localparam longint K_QUARTER  = 16384;
  localparam longint K_BROWN    = 1311;
  localparam longint K_GAIN     = 39322;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic [PEAK_W-1:0]          peak;
  } shaped_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [NOISE_W-1:0] in_noise_value = '0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic signed [SAMPLE_W-1:0] out_shaped_sample;
  logic out_last_frame;
  logic [PEAK_W-1:0] out_peak_magnitude;

  colored_noise_burst_shaper_unit #(
    .MAX_FRAMES(FRAME_CAP)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_noise_value     (in_noise_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_shaped_sample  (out_shaped_sample),
    .out_last_frame     (out_last_frame),
    .out_peak_magnitude (out_peak_magnitude),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow of the block: configuration and burst state.
  logic [COLOR_W-1:0]  color_reg = COLOR_WHITE;
  logic [FRAMES_W-1:0] frames_reg = RESET_FRAMES;
  longint pole_slow = 0;
  longint pole_mid = 0;
  longint pole_fast = 0;
  longint brown_level = 0;
  longint frame_cnt = 0;
  longint peak_seen = 0;

  logic signed [NOISE_W-1:0] noise_backlog[$];
  shaped_beat_t beats_due[$];

  int drv_idle_pct = 29;
  int mon_idle_pct = 29;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  function automatic longint q16(input longint a, input longint coef);
    // Arithmetic shift gives the floor, so ties round toward plus infinity.
    return (a * coef + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic shaped_beat_t shape_frame(input logic signed [NOISE_W-1:0] noise);
    longint wide, level, total, nfr, span, env, y, mag;
    shaped_beat_t beat;
    wide = longint'(noise) * 2;
    level = wide;
    if (color_reg == COLOR_PINK) begin
      pole_slow = clamp32(q16(pole_slow, K_SLOW_FB) + q16(wide, K_SLOW_IN));
      pole_mid  = clamp32(q16(pole_mid, K_MID_FB) + q16(wide, K_MID_IN));
      pole_fast = clamp32(q16(pole_fast, K_FAST_FB) + q16(wide, K_FAST_IN));
      total = pole_slow + pole_mid + pole_fast + q16(wide, K_DIRECT);
      level = q16(total, K_QUARTER);
    end else if (color_reg == COLOR_BROWN) begin
      level = brown_level + q16(wide, K_BROWN);
      if (level < -64'sd65536) level = -64'sd65536;
      if (level > 64'sd65536) level = 64'sd65536;
      brown_level = level;
    end

    nfr = longint'(frames_reg);
    if (nfr == 0) nfr = 1;
    if (nfr > FRAME_CAP) nfr = FRAME_CAP;
    span = (frame_cnt < nfr) ? nfr - frame_cnt : 0;
    env = ((span * span) << 16) / (nfr * nfr);

    y = q16(q16(level, env), K_GAIN);
    if (y > 64'sd8388607) y = 64'sd8388607;
    if (y < -64'sd8388608) y = -64'sd8388608;
    mag = (y < 0) ? -y : y;
    if (mag > 64'sd8388607) mag = 64'sd8388607;
    if (mag > peak_seen) peak_seen = mag;

    beat.sample = y[SAMPLE_W-1:0];
    beat.last = (frame_cnt + 1 >= nfr);
    beat.peak = peak_seen[PEAK_W-1:0];

    if (beat.last) begin
      pole_slow = 0;
      pole_mid = 0;
      pole_fast = 0;
      brown_level = 0;
      frame_cnt = 0;
      peak_seen = 0;
    end else begin
      frame_cnt = frame_cnt + 1;
    end
    return beat;
  endfunction

  // Noise driver: a beat moves when valid is high and stall is low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        beats_due.insert(beats_due.size(), shape_frame(in_noise_value));
      end
      if (!in_valid || !in_stall) begin
        if (noise_backlog.size() > 0 && $urandom_range(99) >= drv_idle_pct) begin
          in_valid <= 1'b1;
          in_noise_value <= noise_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result checker and receiver stall.
  always @(posedge clk) begin
    shaped_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (beats_due.size() == 0) begin
        $error("result beat arrived with nothing expected");
        err_cnt++;
      end else begin
        want = beats_due.pop_front();
        if (out_shaped_sample !== want.sample) begin
          $error("shaped_sample: expected %0d, got %0d", want.sample, out_shaped_sample);
          err_cnt++;
        end
        if (out_last_frame !== want.last) begin
          $error("last_frame: expected %0d, got %0d", want.last, out_last_frame);
          err_cnt++;
        end
        if (out_peak_magnitude !== want.peak) begin
          $error("peak_magnitude: expected %0d, got %0d", want.peak, out_peak_magnitude);
          err_cnt++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < mon_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_noise(input logic signed [NOISE_W-1:0] noise);
    noise_backlog.insert(noise_backlog.size(), noise);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NOISE_COLOR) begin
      color_reg = value[COLOR_W-1:0];
    end else if (idx == REG_BURST_FRAMES) begin
      frames_reg = value;
    end
    @(negedge clk);
  endtask

  // Every beat yields a result, so an empty queue with nothing offered means idle.
  task automatic wait_drained(input int gap);
    do @(negedge clk);
    while (noise_backlog.size() != 0 || in_valid || beats_due.size() != 0);
    repeat (gap) @(negedge clk);
  endtask

  initial begin
    int phase, len, fed, pick;
    logic [CFG_DATA_W-1:0] value;
    logic signed [NOISE_W-1:0] noise;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: white, long burst, full-scale, zero and small inputs.
    push_noise(16'sd32767);
    push_noise(-16'sd32768);
    push_noise(16'sd0);
    push_noise(16'sd1);
    wait_drained(3);

    // Pink with a burst length that ends the current burst right away.
    write_reg(REG_NOISE_COLOR, COLOR_PINK);
    write_reg(REG_BURST_FRAMES, 17'd5);
    push_noise(16'sd32767);
    push_noise(16'sd32767);
    push_noise(16'sd32767);
    push_noise(-16'sd32768);
    push_noise(-16'sd1);
    push_noise(16'sh5555);
    wait_drained(3);

    // Shorten the burst below the current frame and switch to brown mid-burst.
    write_reg(REG_BURST_FRAMES, 17'd10);
    push_noise(16'shAAAA);
    push_noise(16'sd12345);
    push_noise(-16'sd20000);
    wait_drained(3);
    write_reg(REG_NOISE_COLOR, COLOR_BROWN);
    write_reg(REG_BURST_FRAMES, 17'd2);
    push_noise(16'sd32767);
    push_noise(16'sd32767);
    push_noise(16'sd32767);
    push_noise(-16'sd32768);
    wait_drained(3);

    // Zero length acts as one; the spare color code acts as white.
    write_reg(REG_NOISE_COLOR, COLOR_SPARE);
    write_reg(REG_BURST_FRAMES, 17'd0);
    push_noise(-16'sd32768);
    push_noise(16'sd32767);
    wait_drained(3);

    // Overlong burst is capped.
    write_reg(REG_NOISE_COLOR, COLOR_BROWN);
    write_reg(REG_BURST_FRAMES, 17'h1FFFF);
    push_noise(-16'sd32768);
    push_noise(-16'sd32768);
    push_noise(16'sh2AAA);
    wait_drained(3);

    // Writes to unused indexes must leave both registers alone.
    write_reg(REG_SPARE_A, 17'd1);
    write_reg(REG_SPARE_B, 17'h1FFFF);
    push_noise(16'sd7);
    wait_drained(3);

    fed = 0;
    phase = 0;
    while (fed < RANDOM_ITEMS) begin
      if ($urandom_range(3) != 0) begin
        value = CFG_DATA_W'(($urandom_range(4) == 0) ? $urandom_range(131071)
                                                      : $urandom_range(3));
        write_reg(REG_NOISE_COLOR, value);
      end
      if ($urandom_range(3) != 0) begin
        pick = $urandom_range(99);
        if (pick < 65) value = CFG_DATA_W'($urandom_range(40, 1));
        else if (pick < 73) value = 17'd0;
        else if (pick < 80) value = CFG_DATA_W'(FRAME_CAP);
        else if (pick < 86) value = 17'h1FFFF;
        else if (pick < 92) value = CFG_DATA_W'($urandom_range(131070, 65537));
        else value = CFG_DATA_W'($urandom_range(65535, 41));
        write_reg(REG_BURST_FRAMES, value);
      end
      if ($urandom_range(9) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_DATA_W'($urandom_range(131071)));
      end

      drv_idle_pct = 29;
      mon_idle_pct = 29;
      len = $urandom_range(60, 10);
      if (phase == 4) begin
        drv_idle_pct = 0;
        mon_idle_pct = 0;
        len = 250;
      end else if (phase == 8 || phase == 20) begin
        // The receiver holds off while beats keep coming, so the block backs up.
        drv_idle_pct = 0;
        hold_req = 1'b1;
        len = 20;
      end

      repeat (len) begin
        pick = $urandom_range(99);
        if (pick < 10) noise = $urandom_range(1) ? 16'sd32767 : -16'sd32768;
        else if (pick < 25) noise = NOISE_W'(int'($urandom_range(511)) - 256);
        else noise = NOISE_W'($urandom);
        push_noise(noise);
        fed++;
      end
      wait_drained(3);
      phase++;
    end

    wait_drained(SETTLE_CYCLES);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
